@@ design/decimal_text_to_integer_macros.svh @@
// assertion macros for the decimal text parser checker
// needs clk and rst_n in the scope where a macro is used
`ifndef DECIMAL_TEXT_TO_INTEGER_MACROS_SVH
`define DECIMAL_TEXT_TO_INTEGER_MACROS_SVH

// same-cycle implication
`define DTTI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtti check failed");

// next-cycle implication
`define DTTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtti check failed");

`endif

@@ design/dtti_pkg.sv @@
// constants and types for the decimal text parser
// no dependencies
`timescale 1ns / 1ps

package dtti_pkg;

  localparam int MAX_CHARS = 20;
  localparam int CNT_W     = 5;
  localparam int CH_W      = 8;
  localparam int DIG_W     = 4;
  localparam int MAG_W     = 64;
  localparam int RSN_W     = 3;

  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;

  // largest magnitude that can still take one more digit, and the last digit allowed there
  localparam logic [MAG_W-1:0] LIM_DIV = 64'd1844674407370955161;
  localparam logic [DIG_W-1:0] LIM_MOD = 4'd5;

  localparam logic [RSN_W-1:0] RSN_OK       = 3'd0;
  localparam logic [RSN_W-1:0] RSN_EMPTY    = 3'd1;
  localparam logic [RSN_W-1:0] RSN_TOO_LONG = 3'd2;
  localparam logic [RSN_W-1:0] RSN_BAD_CHAR = 3'd3;
  localparam logic [RSN_W-1:0] RSN_RANGE    = 3'd4;

  typedef struct packed {
    logic             empty;
    logic             too_long;
    logic             bad;
    logic             digit;
    logic             range;
    logic             neg;
    logic             mode;
    logic [MAG_W-1:0] mag;
  } snap_t;

endpackage

@@ design/decimal_text_to_integer.sv @@
// decimal text to 64-bit integer parser, top level
// depends on dtti_pkg
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_character, in_last_char, in_empty_text
//  out     | output    | out_valid / out_ready | out_value, out_ok, out_reason
//  cfg     | input     | cfg_wr_en             | cfg_wr_data (signed_mode)
//
// one character per cycle when the output is not stalled; the accumulator
// update (shift-add by ten plus the limit compare) is the single per-item step
// a result passes through the input, snapshot and result registers in turn
// reset clears the text state and signed_mode; there is no clearing pass
// the snapshot and result registers hold while out_valid is high and out_ready low;
// an empty input register still takes one item, then in_ready drops
`timescale 1ns / 1ps

module decimal_text_to_integer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dtti_pkg::CH_W-1:0]           in_character,
  input  logic                                in_last_char,
  input  logic                                in_empty_text,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dtti_pkg::MAG_W-1:0]          out_value,
  output logic                                out_ok,
  output logic [dtti_pkg::RSN_W-1:0]          out_reason
);

  logic                              signed_mode_r;

  logic                              a_valid_r;
  logic [dtti_pkg::CH_W-1:0]         a_char_r;
  logic                              a_last_r;
  logic                              a_empty_r;

  logic [dtti_pkg::MAG_W-1:0]        mag_r, mag_nxt;
  logic [dtti_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                              neg_r, neg_nxt;
  logic                              dig_r, dig_nxt;
  logic                              bad_r, bad_nxt;
  logic                              rng_r, rng_nxt;
  logic                              tl_r, tl_nxt;

  logic                              b_valid_r;
  dtti_pkg::snap_t                   snap_r, snap_nxt;
  logic                              fin;

  logic                              out_valid_r;
  logic [dtti_pkg::MAG_W-1:0]        out_value_r, out_value_nxt;
  logic                              out_ok_r, out_ok_nxt;
  logic [dtti_pkg::RSN_W-1:0]        out_reason_r, out_reason_nxt;

  logic                              adv;
  logic                              fire_b;
  logic                              cnt_full;
  logic [dtti_pkg::CNT_W-1:0]        cnt_step;
  logic                              tl_step;
  logic                              is_digit;
  logic [dtti_pkg::DIG_W-1:0]        digit;
  logic                              ovf;
  logic [dtti_pkg::MAG_W-1:0]        mag_mul;
  logic                              is_minus;
  logic [dtti_pkg::MAG_W-1:0]        mag_step;
  logic                              neg_step, dig_step, bad_step, rng_step;
  logic                              over_half;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !a_valid_r || adv;
  assign fire_b   = a_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      signed_mode_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_char_r  <= in_character;
      a_last_r  <= in_last_char;
      a_empty_r <= in_empty_text;
    end
  end

  // per-character accumulation
  always_comb begin
    cnt_full = cnt_r >= dtti_pkg::CNT_W'(dtti_pkg::MAX_CHARS);
    cnt_step = cnt_full ? cnt_r : cnt_r + dtti_pkg::CNT_W'(1);
    tl_step  = tl_r | cnt_full;
    is_digit = (a_char_r >= dtti_pkg::CH_ZERO) && (a_char_r <= dtti_pkg::CH_NINE);
    digit    = dtti_pkg::DIG_W'(a_char_r - dtti_pkg::CH_ZERO);
    ovf      = (mag_r > dtti_pkg::LIM_DIV) ||
               ((mag_r == dtti_pkg::LIM_DIV) && (digit > dtti_pkg::LIM_MOD));
    mag_mul  = (mag_r << 3) + (mag_r << 1) +
               {{(dtti_pkg::MAG_W-dtti_pkg::DIG_W){1'b0}}, digit};
    is_minus = (a_char_r == dtti_pkg::CH_MINUS) && signed_mode_r && !neg_r && !dig_r &&
               !bad_r && !tl_step && (cnt_step == dtti_pkg::CNT_W'(1));

    mag_step = mag_r;
    neg_step = neg_r;
    dig_step = dig_r;
    bad_step = bad_r;
    rng_step = rng_r;
    if (is_digit) begin
      dig_step = 1'b1;
      if (!rng_r) begin
        if (ovf) begin
          rng_step = 1'b1;
        end else begin
          mag_step = mag_mul;
        end
      end
    end else if (is_minus) begin
      neg_step = 1'b1;
    end else begin
      bad_step = 1'b1;
    end

    snap_nxt.empty    = a_empty_r;
    snap_nxt.too_long = tl_step;
    snap_nxt.bad      = bad_step;
    snap_nxt.digit    = dig_step;
    snap_nxt.range    = rng_step;
    snap_nxt.neg      = neg_step;
    snap_nxt.mode     = signed_mode_r;
    snap_nxt.mag      = mag_step;

    fin = a_empty_r || a_last_r;
    if (fin) begin
      mag_nxt = '0;
      cnt_nxt = '0;
      neg_nxt = 1'b0;
      dig_nxt = 1'b0;
      bad_nxt = 1'b0;
      rng_nxt = 1'b0;
      tl_nxt  = 1'b0;
    end else begin
      mag_nxt = mag_step;
      cnt_nxt = cnt_step;
      neg_nxt = neg_step;
      dig_nxt = dig_step;
      bad_nxt = bad_step;
      rng_nxt = rng_step;
      tl_nxt  = tl_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
      cnt_r <= '0;
      neg_r <= 1'b0;
      dig_r <= 1'b0;
      bad_r <= 1'b0;
      rng_r <= 1'b0;
      tl_r  <= 1'b0;
    end else if (fire_b) begin
      mag_r <= mag_nxt;
      cnt_r <= cnt_nxt;
      neg_r <= neg_nxt;
      dig_r <= dig_nxt;
      bad_r <= bad_nxt;
      rng_r <= rng_nxt;
      tl_r  <= tl_nxt;
    end
  end

  // end-of-text snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= fire_b && fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_b && fin) begin
      snap_r <= snap_nxt;
    end
  end

  // final checks and sign
  always_comb begin
    over_half      = snap_r.mag[dtti_pkg::MAG_W-1] && (|snap_r.mag[dtti_pkg::MAG_W-2:0]);
    out_value_nxt  = '0;
    out_reason_nxt = dtti_pkg::RSN_OK;
    if (snap_r.empty) begin
      out_reason_nxt = dtti_pkg::RSN_EMPTY;
    end else if (snap_r.too_long) begin
      out_reason_nxt = dtti_pkg::RSN_TOO_LONG;
    end else if (snap_r.bad || !snap_r.digit) begin
      out_reason_nxt = dtti_pkg::RSN_BAD_CHAR;
    end else if (snap_r.range) begin
      out_reason_nxt = dtti_pkg::RSN_RANGE;
    end else if (snap_r.neg) begin
      if (over_half) begin
        out_reason_nxt = dtti_pkg::RSN_RANGE;
      end else begin
        out_value_nxt = '0 - snap_r.mag;
      end
    end else if (snap_r.mode && snap_r.mag[dtti_pkg::MAG_W-1]) begin
      out_reason_nxt = dtti_pkg::RSN_RANGE;
    end else begin
      out_value_nxt = snap_r.mag;
    end
    out_ok_nxt = (out_reason_nxt == dtti_pkg::RSN_OK);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid_r) begin
      out_value_r  <= out_value_nxt;
      out_ok_r     <= out_ok_nxt;
      out_reason_r <= out_reason_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_ok     = out_ok_r;
  assign out_reason = out_reason_r;

endmodule

@@ design/dtti_checker.sv @@
// port-level checks for decimal_text_to_integer, bound to the top level
// depends on dtti_pkg and decimal_text_to_integer_macros.svh
`timescale 1ns / 1ps
`include "decimal_text_to_integer_macros.svh"

module dtti_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dtti_pkg::MAG_W-1:0]    out_value,
  input logic                          out_ok,
  input logic [dtti_pkg::RSN_W-1:0]    out_reason
);

  `DTTI_ASSERT_IMPL(a_ok_matches_reason, out_valid, (out_ok == (out_reason == dtti_pkg::RSN_OK)))
  `DTTI_ASSERT_IMPL(a_fail_value_zero, (out_valid && !out_ok), (out_value == '0))
  `DTTI_ASSERT_IMPL(a_reason_known, out_valid, (out_reason <= dtti_pkg::RSN_RANGE))
  `DTTI_ASSERT_NEXT(a_out_held, (out_valid && !out_ready), (out_valid && $stable(out_value)))

endmodule

bind decimal_text_to_integer dtti_checker u_dtti_checker (.*);

@@ test/decimal_text_to_integer_test.sv @@
// self-checking testbench for the decimal text parser: directed texts, then random ones
// depends on dtti_pkg and decimal_text_to_integer
// keeps its own parser state to predict each result, unless a directed case gives a typed one
`timescale 1ns / 1ps

module decimal_text_to_integer_test;

  localparam logic [dtti_pkg::MAG_W-1:0] SIGN_BIT = {1'b1, {(dtti_pkg::MAG_W-1){1'b0}}};
  localparam int TOTAL_ITEMS = 1800;

  typedef logic [dtti_pkg::CH_W-1:0] char_t;

  typedef struct packed {
    logic [dtti_pkg::MAG_W-1:0] value;
    logic                       ok;
    logic [dtti_pkg::RSN_W-1:0] reason;
  } parse_result_t;

  typedef struct {
    string                      text;
    bit                         mode;
    int                         flip_at;
    bit                         empty_end;
    bit                         typed;
    logic [dtti_pkg::MAG_W-1:0] value;
    bit                         ok;
    logic [dtti_pkg::RSN_W-1:0] reason;
  } text_case_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic                       cfg_wr_data = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [dtti_pkg::CH_W-1:0]  in_character = '0;
  logic                       in_last_char = 1'b0;
  logic                       in_empty_text = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [dtti_pkg::MAG_W-1:0] out_value;
  logic                       out_ok;
  logic [dtti_pkg::RSN_W-1:0] out_reason;

  // predicted parser state
  bit                         mode_now = 1'b0;
  logic [dtti_pkg::MAG_W-1:0] mag_acc = '0;
  logic [dtti_pkg::CNT_W-1:0] chars_seen = '0;
  bit                         minus_taken = 1'b0;
  bit                         digit_taken = 1'b0;
  bit                         bad_taken = 1'b0;
  bit                         overflowed = 1'b0;
  bit                         long_taken = 1'b0;

  parse_result_t expected_results[$];
  parse_result_t next_result;
  text_case_t    dir_cases[25];
  int            fail_count = 0;
  int            items_sent = 0;
  int            out_hold = 0;
  bit            send_quiet = 1'b0;
  bit            recv_quiet = 1'b0;

  decimal_text_to_integer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_last_char (in_last_char),
    .in_empty_text(in_empty_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_ok       (out_ok),
    .out_reason   (out_reason)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit parse_step(input char_t ch, input logic last, input logic empty,
                                    output parse_result_t res);
    logic [dtti_pkg::DIG_W-1:0] d;
    bit done;
    res = '0;
    done = 1'b0;
    if (empty) begin
      res.reason = dtti_pkg::RSN_EMPTY;
      done = 1'b1;
    end else begin
      if (chars_seen >= dtti_pkg::MAX_CHARS) long_taken = 1'b1;
      else chars_seen = chars_seen + 1'b1;
      if (ch >= dtti_pkg::CH_ZERO && ch <= dtti_pkg::CH_NINE) begin
        d = dtti_pkg::DIG_W'(ch - dtti_pkg::CH_ZERO);
        digit_taken = 1'b1;
        if (!overflowed) begin
          if (mag_acc > dtti_pkg::LIM_DIV ||
              (mag_acc == dtti_pkg::LIM_DIV && d > dtti_pkg::LIM_MOD)) overflowed = 1'b1;
          else mag_acc = mag_acc * 64'd10 + dtti_pkg::MAG_W'(d);
        end
      end else if (ch == dtti_pkg::CH_MINUS && mode_now && !minus_taken && !digit_taken &&
                   !bad_taken && !long_taken && chars_seen == 1) begin
        minus_taken = 1'b1;
      end else begin
        bad_taken = 1'b1;
      end
      if (last) begin
        done = 1'b1;
        if (long_taken) res.reason = dtti_pkg::RSN_TOO_LONG;
        else if (bad_taken || !digit_taken) res.reason = dtti_pkg::RSN_BAD_CHAR;
        else if (overflowed) res.reason = dtti_pkg::RSN_RANGE;
        else if (minus_taken) begin
          if (mag_acc > SIGN_BIT) res.reason = dtti_pkg::RSN_RANGE;
          else begin
            res.value = '0 - mag_acc;
            res.ok = 1'b1;
            res.reason = dtti_pkg::RSN_OK;
          end
        end else if (mode_now && mag_acc > SIGN_BIT - 1) begin
          res.reason = dtti_pkg::RSN_RANGE;
        end else begin
          res.value = mag_acc;
          res.ok = 1'b1;
          res.reason = dtti_pkg::RSN_OK;
        end
      end
    end
    if (done) begin
      mag_acc = '0;
      chars_seen = '0;
      minus_taken = 1'b0;
      digit_taken = 1'b0;
      bad_taken = 1'b0;
      overflowed = 1'b0;
      long_taken = 1'b0;
    end
    return done;
  endfunction

  task automatic send_item(input char_t ch, input logic last, input logic empty,
                           input bit use_fixed, input parse_result_t fixed);
    int gap;
    parse_result_t res;
    if ($urandom_range(0, 49) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_character <= ch;
    in_last_char <= last;
    in_empty_text <= empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (parse_step(ch, last, empty, res)) expected_results.push_back(use_fixed ? fixed : res);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // characters that end no text may still be in the pipeline
    repeat (6) @(posedge clk);
  endtask

  task automatic write_signed_mode(input bit mode);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    mode_now = mode;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_text(input char_t txt[$], input bit empty_end, input int flip_at,
                           input bit use_fixed, input parse_result_t fixed);
    int i;
    for (i = 0; i < txt.size(); i++) begin
      send_item(txt[i], !empty_end && (i == txt.size() - 1), 1'b0, use_fixed, fixed);
      if (i == flip_at) write_signed_mode(!mode_now);
    end
    if (empty_end)
      send_item(char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                use_fixed, fixed);
  endtask

  task automatic send_random_text();
    char_t txt[$];
    string base;
    int kind, len, pos, i;
    bit empty_end;
    kind = $urandom_range(0, 99);
    empty_end = 1'b0;
    if (kind < 45) begin
      // well-formed number, minus sign only where it is legal
      if (mode_now && $urandom_range(0, 1)) txt.push_back(dtti_pkg::CH_MINUS);
      len = $urandom_range(1, dtti_pkg::MAX_CHARS - txt.size());
      repeat (len) txt.push_back(char_t'(dtti_pkg::CH_ZERO + $urandom_range(0, 9)));
    end else if (kind < 65) begin
      // around the range limits
      case ($urandom_range(0, 2))
        0: base = "18446744073709551615";
        1: base = "9223372036854775807";
        default: base = "-9223372036854775808";
      endcase
      for (i = 0; i < base.len(); i++) txt.push_back(base[i]);
      txt[txt.size() - 1] = char_t'(dtti_pkg::CH_ZERO + $urandom_range(0, 9));
      if ($urandom_range(0, 3) == 0)
        txt[txt.size() - 2] = char_t'(dtti_pkg::CH_ZERO + $urandom_range(0, 9));
    end else if (kind < 75) begin
      len = $urandom_range(1, dtti_pkg::MAX_CHARS);
      repeat (len) txt.push_back(char_t'(dtti_pkg::CH_ZERO + $urandom_range(0, 9)));
      pos = $urandom_range(0, len - 1);
      txt[pos] = char_t'($urandom_range(0, 255));
    end else if (kind < 85) begin
      if ($urandom_range(0, 1)) txt.push_back(dtti_pkg::CH_MINUS);
      len = $urandom_range(dtti_pkg::MAX_CHARS + 1, dtti_pkg::MAX_CHARS + 6) - txt.size();
      repeat (len) txt.push_back(char_t'(dtti_pkg::CH_ZERO + $urandom_range(0, 9)));
    end else if (kind < 93) begin
      // empty text, sometimes cutting a partial one short
      len = $urandom_range(0, 5);
      repeat (len) txt.push_back(char_t'(dtti_pkg::CH_ZERO + $urandom_range(0, 9)));
      empty_end = 1'b1;
    end else begin
      len = $urandom_range(1, 6);
      repeat (len) txt.push_back(char_t'($urandom_range(0, 255)));
    end
    send_text(txt, empty_end, -1, 1'b0, '0);
  endtask

  // result side: random stalls, check each item against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item expected: value %h ok %b reason %0d",
                 out_value, out_ok, out_reason);
          fail_count++;
        end else begin
          next_result = expected_results.pop_front();
          if (out_value !== next_result.value) begin
            $error("value: expected %h, actual %h", next_result.value, out_value);
            fail_count++;
          end
          if (out_ok !== next_result.ok) begin
            $error("ok: expected %b, actual %b", next_result.ok, out_ok);
            fail_count++;
          end
          if (out_reason !== next_result.reason) begin
            $error("reason: expected %0d, actual %0d", next_result.reason, out_reason);
            fail_count++;
          end
        end
        if ($urandom_range(0, 49) == 0) recv_quiet = !recv_quiet;
        out_hold = recv_quiet ? 0 : $urandom_range(0, 9);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_ready <= (out_hold == 0);
    end
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int i, j, rand_goal, texts;
    char_t txt[$];
    parse_result_t fixed;
    dir_cases = '{
      '{"", 1'b0, -1, 1'b1, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_EMPTY},
      '{"0", 1'b0, -1, 1'b0, 1'b1, 64'd0, 1'b1, dtti_pkg::RSN_OK},
      '{"18446744073709551615", 1'b0, -1, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        dtti_pkg::RSN_OK},
      '{"18446744073709551616", 1'b0, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_RANGE},
      '{"99999999999999999999", 1'b0, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_RANGE},
      '{"00000000000000000001", 1'b0, -1, 1'b0, 1'b1, 64'd1, 1'b1, dtti_pkg::RSN_OK},
      '{"000000000000000000001", 1'b0, -1, 1'b0, 1'b1, 64'd0, 1'b0,
        dtti_pkg::RSN_TOO_LONG},
      '{"a00000000000000000000", 1'b0, -1, 1'b0, 1'b1, 64'd0, 1'b0,
        dtti_pkg::RSN_TOO_LONG},
      '{"-5", 1'b0, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_BAD_CHAR},
      '{"+5", 1'b1, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_BAD_CHAR},
      '{"-", 1'b1, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_BAD_CHAR},
      '{"/:", 1'b0, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_BAD_CHAR},
      '{"12a", 1'b0, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_BAD_CHAR},
      '{"--1", 1'b1, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_BAD_CHAR},
      '{"1-", 1'b1, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_BAD_CHAR},
      '{"-9223372036854775808", 1'b1, -1, 1'b0, 1'b1, 64'h8000_0000_0000_0000, 1'b1,
        dtti_pkg::RSN_OK},
      '{"-9223372036854775809", 1'b1, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_RANGE},
      '{"9223372036854775807", 1'b1, -1, 1'b0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
        dtti_pkg::RSN_OK},
      '{"9223372036854775808", 1'b1, -1, 1'b0, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_RANGE},
      '{"-0", 1'b1, -1, 1'b0, 1'b1, 64'd0, 1'b1, dtti_pkg::RSN_OK},
      '{"123", 1'b0, -1, 1'b1, 1'b1, 64'd0, 1'b0, dtti_pkg::RSN_EMPTY},
      '{"-42", 1'b1, 0, 1'b0, 1'b0, 64'd0, 1'b0, dtti_pkg::RSN_OK},
      '{"9223372036854775808", 1'b0, 0, 1'b0, 1'b0, 64'd0, 1'b0, dtti_pkg::RSN_OK},
      '{"4095", 1'b1, -1, 1'b0, 1'b0, 64'd0, 1'b0, dtti_pkg::RSN_OK},
      '{"-1844674407370955161", 1'b1, -1, 1'b0, 1'b0, 64'd0, 1'b0, dtti_pkg::RSN_OK}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < $size(dir_cases); i++) begin
      if (dir_cases[i].mode != mode_now) write_signed_mode(dir_cases[i].mode);
      txt.delete();
      for (j = 0; j < dir_cases[i].text.len(); j++) txt.push_back(dir_cases[i].text[j]);
      fixed.value = dir_cases[i].value;
      fixed.ok = dir_cases[i].ok;
      fixed.reason = dir_cases[i].reason;
      send_text(txt, dir_cases[i].empty_end, dir_cases[i].flip_at, dir_cases[i].typed, fixed);
    end

    rand_goal = TOTAL_ITEMS;
    while (items_sent < rand_goal) begin
      write_signed_mode(1'($urandom_range(0, 1)));
      texts = $urandom_range(10, 40);
      repeat (texts) if (items_sent < rand_goal) send_random_text();
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ decimal_text_to_integer.f @@
+incdir+design
design/dtti_pkg.sv
design/decimal_text_to_integer.sv
design/dtti_checker.sv
test/decimal_text_to_integer_test.sv
